// ----- rtl/core/gls_pkg.sv -----
// Package with types, codes and constants shared by the spectrum accumulator files.
`timescale 1ns / 1ps

package gls_pkg;

  localparam int MAX_BINS_DEF  = 1024;
  localparam int EXP_DEPTH_DEF = 256;
  localparam int SUM_WIDTH_DEF = 48;

  // Widths wide enough for the largest MAX_BINS.
  localparam int IDX_W = 16;
  localparam int CNT_W = 17;

  // 12400000 eV*mA in Q.8.
  localparam logic [31:0] LINE_NUM       = 32'd3174400000;
  localparam logic [63:0] EXP_NEG_ONE    = 64'd1580030169;
  localparam logic [36:0] CUTOFF_Q8      = 37'd4096;
  localparam logic [21:0] ENERGY_MAX     = 22'h3FFFFF;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [2:0] REG_GRID_START = 3'd0;
  localparam logic [2:0] REG_GRID_STEP  = 3'd1;
  localparam logic [2:0] REG_BINS       = 3'd2;
  localparam logic [2:0] REG_PEAK_SCALE = 3'd3;
  localparam logic [2:0] REG_EXP_SCALE  = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [23:0] wavelength_milliangstrom;
    logic [31:0] line_intensity;
    logic [9:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic [21:0] bin_energy_ev;
    logic [47:0] bin_sum;
    logic        bin_saturated;
  } out_item_t;

  typedef struct packed {
    logic [15:0] grid_start_ev;
    logic [11:0] grid_step_ev;
    logic [10:0] bins_in_use;
    logic [31:0] peak_amplitude_scale;
    logic [31:0] exponent_scale;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [IDX_W-1:0] bin;
    logic             load_out;
    logic             clr_we;
    logic [IDX_W-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic             req_read;
    logic             req_null;
    logic             div_done;
    logic             div_busy;
    logic             pipe_empty;
    logic             out_free;
    logic [CNT_W-1:0] active;
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_RDATA
  } state_t;

endpackage

// ----- rtl/core/gls_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the line energy.
`timescale 1ns / 1ps

module gls_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [23:0] divisor,
  output logic [31:0] quotient,
  output logic        busy,
  output logic        done
);

  logic [31:0] numr;
  logic [23:0] den;
  logic [24:0] rem;
  logic [4:0]  cnt;
  logic [24:0] rem_sh;
  logic        fits;

  always_comb begin
    rem_sh = {rem[23:0], numr[31]};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numr     <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      numr     <= {numr[30:0], 1'b0};
      rem      <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
      quotient <= {quotient[30:0], fits};
    end
  end

endmodule

// ----- rtl/core/gls_datapath.sv -----
// Datapath: line setup, per-bin Gaussian pipeline, spectrum memory and result register.
`timescale 1ns / 1ps

module gls_datapath #(
  parameter int MAX_BINS        = gls_pkg::MAX_BINS_DEF,
  parameter int EXP_TABLE_DEPTH = gls_pkg::EXP_DEPTH_DEF,
  parameter int SUM_WIDTH       = gls_pkg::SUM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  gls_pkg::cfg_t      cfg,
  input  gls_pkg::in_item_t  req_data,
  input  gls_pkg::cmd_t      cmd,
  output gls_pkg::status_t   status,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output gls_pkg::out_item_t rsp_data
);

  import gls_pkg::*;

  localparam int IW  = $clog2(MAX_BINS);
  localparam int RIW = $clog2(EXP_TABLE_DEPTH);

  // Entry i of the table is exp(-16 i / depth) in Q1.16, built from a series.
  function automatic logic [16:0] exp_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] rr;
    longint      sum;
    x    = (64'(i) << 36) / EXP_TABLE_DEPTH;
    n    = x >> 32;
    f    = x & 64'hFFFF_FFFF;
    term = 64'h1_0000_0000;
    sum  = longint'(term);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * f) >> 32) / 64'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    r = (sum < 0) ? 64'd0 : 64'(sum);
    for (int k = 0; k < 16; k++) begin
      if (64'(k) < n && r != 64'd0) r = (r * EXP_NEG_ONE + 64'h8000_0000) >> 32;
    end
    rr = (r + 64'h8000) >> 16;
    return rr[16:0];
  endfunction

  logic [16:0] rom [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign rom[g] = exp_entry(g);
  end

  // Bin word: saturation mark on top of the sum.
  logic [SUM_WIDTH:0] mem [MAX_BINS];
  logic [SUM_WIDTH:0] mem_rd;
  logic [IW-1:0]      rd_addr;

  localparam logic [SUM_WIDTH-1:0] TOP = {SUM_WIDTH{1'b1}};

  logic [CNT_W-1:0] active;
  logic [63:0]      p_reg;
  logic [IW-1:0]    rd_idx;
  logic             rd_oor;
  logic [21:0]      rd_energy;
  logic [31:0]      line;
  logic             div_start;

  logic [15:0] bi16;
  logic [22:0] e_c;

  logic [8:1]    v;
  logic [IW-1:0] q [8:1];
  logic [36:0]   eb1;
  logic [31:0]   d2;
  logic          far2, far3, far4, cut5;
  logic [63:0]   sq3;
  logic [63:0]   a4;
  logic [31:0]   b4;
  logic [RIW-1:0] idx5;
  logic [16:0]   t6;
  logic [48:0]   mh7;
  logic [16:0]   ml7;
  logic [32:0]   term8;

  logic [36:0]   diff_c;
  logic [63:0]   bprod_c;
  logic [44:0]   sum45_c;
  logic [36:0]   xq_c;
  logic [24:0]   ip_c;
  logic [24:0]   ips_c;
  logic [48:0]   plprod_c;
  logic [48:0]   tsum_c;
  logic [64:0]   acc_c;
  logic [SUM_WIDTH:0] new_word_c;
  logic [63:0]   sum64_c;

  always_comb begin
    active = (CNT_W'(cfg.bins_in_use) > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS)
                                                          : CNT_W'(cfg.bins_in_use);
    bi16   = 16'(req_data.bin_index);
    e_c    = 23'(cfg.grid_start_ev) + 23'(req_data.bin_index) * 23'(cfg.grid_step_ev);
    div_start = cmd.load && (req_data.req_type == REQ_ADD)
                && (req_data.wavelength_milliangstrom != 24'd0);
  end

  gls_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (LINE_NUM + 32'(req_data.wavelength_milliangstrom >> 1)),
    .divisor  (req_data.wavelength_milliangstrom),
    .quotient (line),
    .busy     (status.div_busy),
    .done     (status.div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_reg     <= 64'(req_data.line_intensity) * 64'(cfg.peak_amplitude_scale);
      rd_idx    <= bi16[IW-1:0];
      rd_oor    <= CNT_W'(req_data.bin_index) >= active;
      rd_energy <= (e_c > 23'(ENERGY_MAX)) ? ENERGY_MAX : e_c[21:0];
    end
  end

  always_comb begin
    diff_c   = (eb1 > 37'(line)) ? (eb1 - 37'(line)) : (37'(line) - eb1);
    bprod_c  = 64'(sq3[31:0]) * 64'(cfg.exponent_scale);
    sum45_c  = a4[44:0] + 45'(b4);
    xq_c     = 37'(sum45_c >> 8);
    ip_c     = 25'(xq_c[11:0]) * 25'(EXP_TABLE_DEPTH);
    ips_c    = ip_c >> 12;
    plprod_c = 49'(p_reg[31:0]) * 49'(t6);
    tsum_c   = mh7 + 49'(ml7);
    acc_c    = 65'(mem_rd[SUM_WIDTH-1:0]) + 65'(term8);
    if (acc_c > 65'(TOP)) new_word_c = {1'b1, TOP};
    else                  new_word_c = {mem_rd[SUM_WIDTH], acc_c[SUM_WIDTH-1:0]};
    sum64_c  = 64'(mem_rd[SUM_WIDTH-1:0]);
    rd_addr  = v[7] ? q[7] : rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= {v[7:1], cmd.issue};
  end

  always_ff @(posedge clk) begin
    q[1]  <= cmd.bin[IW-1:0];
    for (int s = 2; s <= 8; s++) q[s] <= q[s-1];
    eb1   <= {29'(cfg.grid_start_ev) + 29'(cmd.bin[IW-1:0]) * 29'(cfg.grid_step_ev), 8'b0};
    d2    <= diff_c[31:0];
    far2  <= |diff_c[36:32];
    sq3   <= 64'(d2) * 64'(d2);
    far3  <= far2;
    a4    <= 64'(sq3[63:32]) * 64'(cfg.exponent_scale);
    b4    <= bprod_c[63:32];
    far4  <= far3;
    cut5  <= far4 || (|a4[63:44]) || (xq_c >= CUTOFF_Q8);
    idx5  <= ips_c[RIW-1:0];
    t6    <= cut5 ? 17'd0 : rom[idx5];
    mh7   <= 49'(p_reg[63:32]) * 49'(t6);
    ml7   <= plprod_c[48:32];
    term8 <= tsum_c[48:16];
  end

  always_ff @(posedge clk) begin
    mem_rd <= mem[rd_addr];
    if (cmd.clr_we)  mem[cmd.clr_addr[IW-1:0]] <= '0;
    else if (v[8])   mem[q[8]] <= new_word_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (rd_oor) begin
        rsp_data <= '0;
      end else begin
        rsp_data.bin_energy_ev <= rd_energy;
        rsp_data.bin_sum       <= sum64_c[47:0];
        rsp_data.bin_saturated <= mem_rd[SUM_WIDTH];
      end
    end
  end

  assign status.req_read   = req_data.req_type == REQ_READ;
  assign status.req_null   = req_data.wavelength_milliangstrom == 24'd0;
  assign status.pipe_empty = !(|v);
  assign status.out_free   = !rsp_valid || !rsp_stall;
  assign status.active     = active;

`ifndef ASSERT_OFF
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_we && v[8]))
    else $error("clearing write collides with a bin update");
  a_read_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(|v))
    else $error("read result taken while the bin pipeline is busy");
  a_issue_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !status.div_busy)
    else $error("bin issued before the line energy is ready");
`endif

endmodule

// ----- rtl/core/gls_controller.sv -----
// Controller state machine: clearing pass, line sweep and bin reads.
`timescale 1ns / 1ps

module gls_controller #(
  parameter int MAX_BINS = gls_pkg::MAX_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  gls_pkg::status_t status,
  output gls_pkg::cmd_t    cmd
);

  import gls_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] bin_cnt, bin_cnt_next;
  logic [CNT_W-1:0] clr_cnt, clr_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      bin_cnt <= '0;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      bin_cnt <= bin_cnt_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    bin_cnt_next = bin_cnt;
    clr_cnt_next = clr_cnt;
    cmd          = '0;
    cmd.bin      = bin_cnt[IDX_W-1:0];
    cmd.clr_addr = clr_cnt[IDX_W-1:0];
    req_stall    = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we   = 1'b1;
        clr_cnt_next = clr_cnt + CNT_W'(1);
        if (clr_cnt == CNT_W'(MAX_BINS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load = 1'b1;
          if (status.req_read)      state_next = ST_READ;
          else if (!status.req_null) state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        bin_cnt_next = '0;
        if (status.div_done) begin
          state_next = (status.active == '0) ? ST_DRAIN : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.issue    = 1'b1;
        bin_cnt_next = bin_cnt + CNT_W'(1);
        if (bin_cnt == status.active - CNT_W'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_empty) state_next = ST_IDLE;
      end
      ST_READ: begin
        // The memory read register picks up the bin during this cycle.
        state_next = ST_RDATA;
      end
      ST_RDATA: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> bin_cnt < status.active)
    else $error("bin counter beyond bins in use");
  a_clear_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> clr_cnt < CNT_W'(MAX_BINS))
    else $error("clearing pass beyond memory depth");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> state == ST_DIV || state == ST_SWEEP || state == ST_DRAIN)
    else $error("divide wait left to an unexpected state");
`endif

endmodule

// ----- rtl/core/gaussian_line_spectrum_accumulator.sv -----
// Add-line item: divide, then issue one bin a cycle, then drain the 8-stage bin pipeline.
// Read: memory read, then result registered when output is free; next request the cycle after.
// One request at a time; the bin pipeline and the spectrum memory port set the add rate.
// After reset a clearing pass over all MAX_BINS words zeroes the spectrum; requests wait for it.
// Registers reset to start 10, step 10, 1000 bins, both scales zero.
`timescale 1ns / 1ps

module gaussian_line_spectrum_accumulator #(
  parameter int MAX_BINS        = gls_pkg::MAX_BINS_DEF,
  parameter int EXP_TABLE_DEPTH = gls_pkg::EXP_DEPTH_DEF,
  parameter int SUM_WIDTH       = gls_pkg::SUM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  gls_pkg::in_item_t  req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output gls_pkg::out_item_t rsp_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import gls_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_start_ev        <= 16'd10;
      cfg.grid_step_ev         <= 12'd10;
      cfg.bins_in_use          <= 11'd1000;
      cfg.peak_amplitude_scale <= '0;
      cfg.exponent_scale       <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_GRID_START: cfg.grid_start_ev        <= pwdata[15:0];
        REG_GRID_STEP:  cfg.grid_step_ev         <= pwdata[11:0];
        REG_BINS:       cfg.bins_in_use          <= pwdata[10:0];
        REG_PEAK_SCALE: cfg.peak_amplitude_scale <= pwdata;
        REG_EXP_SCALE:  cfg.exponent_scale       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GRID_START: prdata = 32'(cfg.grid_start_ev);
      REG_GRID_STEP:  prdata = 32'(cfg.grid_step_ev);
      REG_BINS:       prdata = 32'(cfg.bins_in_use);
      REG_PEAK_SCALE: prdata = cfg.peak_amplitude_scale;
      REG_EXP_SCALE:  prdata = cfg.exponent_scale;
      default:        prdata = '0;
    endcase
  end

  gls_controller #(
    .MAX_BINS (MAX_BINS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gls_datapath #(
    .MAX_BINS        (MAX_BINS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .SUM_WIDTH       (SUM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_data  (req_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
